>>> hdl/assert_macros.svh
// Shared assertion macros for the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hdl/arpc_pkg.sv
package arpc_pkg;

   localparam int CACHE_DEPTH = 16;
   localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

   localparam int MAC_W = 48;
   localparam int IP_W = 32;
   localparam int RXOP_W = 16;
   localparam int OP_W = 2;
   localparam int SLOT_W = 4;
   localparam int ENTRY_W = MAC_W + IP_W;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 64;

   localparam logic [RXOP_W-1:0] RX_OP_REQUEST = 16'h0001;
   localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
   localparam logic [OP_W-1:0] OP_REPLY = 2'd2;
   localparam logic REQ_RECEIVED = 1'b0;
   localparam logic REQ_SEND = 1'b1;
   localparam logic [PADDR_W-1:0] ADDR_OWN_MAC = 4'h0;
   localparam logic [MAC_W-1:0] BROADCAST_MAC = {MAC_W{1'b1}};

   typedef struct packed {
      logic capture;
      logic emit_send;
      logic scan_start;
      logic scan_step;
      logic finish_hit;
      logic finish_miss;
   } arpc_cmd_type;

   typedef struct packed {
      logic is_send;
      logic drop;
      logic count_zero;
      logic rd_valid;
      logic match;
      logic last;
   } arpc_stat_type;

endpackage

>>> hdl/arpc_ram.sv
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/arpc_ctrl.sv
module arpc_ctrl import arpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  arpc_stat_type stat,
   output arpc_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (stat.is_send) begin
                  cmd.emit_send = 1'b1;
               end else if (!stat.drop) begin
                  cmd.capture = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (stat.count_zero) begin
               cmd.finish_miss = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.rd_valid && stat.match) begin
               cmd.finish_hit = 1'b1;
               state_in = ST_IDLE;
            end else if (stat.rd_valid && stat.last) begin
               cmd.finish_miss = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hdl/arpc_dp.sv
module arpc_dp import arpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  arpc_cmd_type      cmd,
   output arpc_stat_type     stat,
   input  logic              cfg_we,
   input  logic [MAC_W-1:0]  cfg_mac,
   output logic [MAC_W-1:0]  own_mac,
   input  logic              req_type,
   input  logic [RXOP_W-1:0] req_rx_opcode,
   input  logic [MAC_W-1:0]  req_sender_mac,
   input  logic [IP_W-1:0]   req_sender_ip,
   input  logic [IP_W-1:0]   req_request_ip,
   output logic              rsp_valid,
   output logic [OP_W-1:0]   rsp_frame_opcode,
   output logic [MAC_W-1:0]  rsp_dest_mac,
   output logic [IP_W-1:0]   rsp_dest_ip,
   output logic [SLOT_W-1:0] rsp_slot_used,
   output logic              rsp_slot_new,
   output logic              rsp_cache_full
);

   logic [MAC_W-1:0]   own_mac_ff, own_mac_in;
   logic [MAC_W-1:0]   smac_ff, smac_in;
   logic [IP_W-1:0]    sip_ff, sip_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [MAC_W-1:0]   dmac_ff, dmac_in;
   logic [IP_W-1:0]    dip_ff, dip_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               new_ff, new_in;
   logic               full_ff, full_in;

   logic               issue;
   logic               is_full;
   logic               mac_differs;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] rd_entry;
   logic [IP_W-1:0]    rd_ip;
   logic [MAC_W-1:0]   rd_mac;

   arpc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CACHE_DEPTH)
   ) u_cache (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({smac_ff, sip_ff}),
      .rd_addr(scan_idx_ff[IDX_W-1:0]),
      .rd_data(rd_entry)
   );

   assign rd_ip = rd_entry[IP_W-1:0];
   assign rd_mac = rd_entry[ENTRY_W-1:IP_W];
   assign issue = (scan_idx_ff < count_ff);
   assign is_full = (count_ff == CNT_W'(CACHE_DEPTH));
   assign mac_differs = (rd_mac != smac_ff);

   // A hit writes back only when the stored address actually changes.
   assign wr_en = (cmd.finish_hit && mac_differs) || (cmd.finish_miss && !is_full);
   assign wr_addr = cmd.finish_hit ? cmp_idx_ff : count_ff[IDX_W-1:0];

   always_comb begin
      stat.is_send = (req_type == REQ_SEND);
      stat.drop = (req_sender_mac == own_mac_ff) || (req_rx_opcode != RX_OP_REQUEST);
      stat.count_zero = (count_ff == '0);
      stat.rd_valid = rd_valid_ff;
      stat.match = (rd_ip == sip_ff);
      stat.last = (CNT_W'(cmp_idx_ff) == count_ff - CNT_W'(1));
   end

   always_comb begin
      own_mac_in = cfg_we ? cfg_mac : own_mac_ff;
      smac_in = cmd.capture ? req_sender_mac : smac_ff;
      sip_in = cmd.capture ? req_sender_ip : sip_ff;
      count_in = count_ff;
      scan_idx_in = scan_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      rd_valid_in = 1'b0;

      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (cmd.scan_step) begin
         rd_valid_in = issue;
         cmp_idx_in = scan_idx_ff[IDX_W-1:0];
         if (issue) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
      end

      if (cmd.finish_miss && !is_full) begin
         count_in = count_ff + CNT_W'(1);
      end

      rsp_valid_in = 1'b0;
      op_in = op_ff;
      dmac_in = dmac_ff;
      dip_in = dip_ff;
      slot_in = slot_ff;
      new_in = new_ff;
      full_in = full_ff;

      if (cmd.emit_send) begin
         rsp_valid_in = 1'b1;
         op_in = OP_REQUEST;
         dmac_in = BROADCAST_MAC;
         dip_in = req_request_ip;
         slot_in = '0;
         new_in = 1'b0;
         full_in = 1'b0;
      end else if (cmd.finish_hit) begin
         rsp_valid_in = 1'b1;
         op_in = OP_REPLY;
         dmac_in = smac_ff;
         dip_in = sip_ff;
         slot_in = SLOT_W'(cmp_idx_ff);
         new_in = 1'b0;
         full_in = 1'b0;
      end else if (cmd.finish_miss) begin
         rsp_valid_in = 1'b1;
         op_in = OP_REPLY;
         dmac_in = smac_ff;
         dip_in = sip_ff;
         slot_in = is_full ? '0 : SLOT_W'(count_ff);
         new_in = !is_full;
         full_in = is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         own_mac_ff <= own_mac_in;
         count_ff <= count_in;
         rd_valid_ff <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smac_ff <= smac_in;
      sip_ff <= sip_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      op_ff <= op_in;
      dmac_ff <= dmac_in;
      dip_ff <= dip_in;
      slot_ff <= slot_in;
      new_ff <= new_in;
      full_ff <= full_in;
   end

   assign own_mac = own_mac_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_opcode = op_ff;
   assign rsp_dest_mac = dmac_ff;
   assign rsp_dest_ip = dip_ff;
   assign rsp_slot_used = slot_ff;
   assign rsp_slot_new = new_ff;
   assign rsp_cache_full = full_ff;

endmodule

>>> hdl/arp_responder_with_cache.sv
// Send requests and dropped frames leave busy low, and a send result follows in the next cycle.
// A received ARP request scans the cache one slot per cycle through the registered RAM port:
// a miss replies once the last cached entry has been compared, a hit as soon as its slot
// matches, and an empty cache replies without a read; busy is high while the scan runs and
// is low again when the result appears. Results are one-cycle strobes, never stalled.
// Synchronous active-high reset clears the entry count, own MAC and control state at once.
`include "assert_macros.svh"

module arp_responder_with_cache import arpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [RXOP_W-1:0]  req_rx_opcode,
   input  logic [MAC_W-1:0]   req_sender_mac,
   input  logic [IP_W-1:0]    req_sender_ip,
   input  logic [IP_W-1:0]    req_request_ip,
   output logic               rsp_valid,
   output logic [OP_W-1:0]    rsp_frame_opcode,
   output logic [MAC_W-1:0]   rsp_dest_mac,
   output logic [IP_W-1:0]    rsp_dest_ip,
   output logic [SLOT_W-1:0]  rsp_slot_used,
   output logic               rsp_slot_new,
   output logic               rsp_cache_full,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   arpc_cmd_type     cmd;
   arpc_stat_type    stat;
   logic             cfg_we;
   logic [MAC_W-1:0] own_mac;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr == ADDR_OWN_MAC);
   assign prdata = (paddr == ADDR_OWN_MAC) ? PDATA_W'(own_mac) : '0;

   arpc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   arpc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cfg_we          (cfg_we),
      .cfg_mac         (pwdata[MAC_W-1:0]),
      .own_mac         (own_mac),
      .req_type        (req_type),
      .req_rx_opcode   (req_rx_opcode),
      .req_sender_mac  (req_sender_mac),
      .req_sender_ip   (req_sender_ip),
      .req_request_ip  (req_request_ip),
      .rsp_valid       (rsp_valid),
      .rsp_frame_opcode(rsp_frame_opcode),
      .rsp_dest_mac    (rsp_dest_mac),
      .rsp_dest_ip     (rsp_dest_ip),
      .rsp_slot_used   (rsp_slot_used),
      .rsp_slot_new    (rsp_slot_new),
      .rsp_cache_full  (rsp_cache_full)
   );

   `ASSERT_NEXT(a_send_emits, clock, reset, start && !busy && (req_type == REQ_SEND),
      rsp_valid && (rsp_frame_opcode == OP_REQUEST))
   `ASSERT_NEXT(a_self_dropped, clock, reset,
      start && !busy && (req_type == REQ_RECEIVED) && (req_sender_mac == own_mac),
      !rsp_valid && !busy)
   `ASSERT_SAME(a_result_ends_busy, clock, reset, rsp_valid, !busy)
   `ASSERT_SAME(a_new_not_full, clock, reset, rsp_valid && rsp_slot_new, !rsp_cache_full)

endmodule

>>> tb/arp_checker.sv
`timescale 1ns / 100ps

module arp_checker import arpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_type,
   input  logic [RXOP_W-1:0]  req_rx_opcode,
   input  logic [MAC_W-1:0]   req_sender_mac,
   input  logic [IP_W-1:0]    req_sender_ip,
   input  logic [IP_W-1:0]    req_request_ip,
   input  logic               rsp_valid,
   input  logic [OP_W-1:0]    rsp_frame_opcode,
   input  logic [MAC_W-1:0]   rsp_dest_mac,
   input  logic [IP_W-1:0]    rsp_dest_ip,
   input  logic [SLOT_W-1:0]  rsp_slot_used,
   input  logic               rsp_slot_new,
   input  logic               rsp_cache_full,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [MAC_W-1:0]  mac;
      logic [IP_W-1:0]   ip;
      logic [SLOT_W-1:0] slot;
      logic              is_new;
      logic              full;
   } arp_frame_type;

   arp_frame_type    frames_due[$];
   logic [IP_W-1:0]  ip_cache[CACHE_DEPTH];
   logic [MAC_W-1:0] mac_cache[CACHE_DEPTH];
   int               entries;
   logic [MAC_W-1:0] own_mac_copy;

   function automatic bit predict_arp_answer(input logic kind, input logic [RXOP_W-1:0] op,
                                             input logic [MAC_W-1:0] mac,
                                             input logic [IP_W-1:0] sip,
                                             input logic [IP_W-1:0] rip,
                                             output arp_frame_type frame);
      bit hit;
      int slot;
      hit = 1'b0;
      slot = 0;
      frame = '0;
      if (kind == REQ_SEND) begin
         frame.opcode = OP_REQUEST;
         frame.mac = BROADCAST_MAC;
         frame.ip = rip;
         return 1'b1;
      end
      if (mac == own_mac_copy || op != RX_OP_REQUEST)
         return 1'b0;
      for (int i = 0; i < entries; i++) begin
         if (!hit && ip_cache[i] == sip) begin
            mac_cache[i] = mac;
            slot = i;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (entries < CACHE_DEPTH) begin
            ip_cache[entries] = sip;
            mac_cache[entries] = mac;
            slot = entries;
            entries++;
            frame.is_new = 1'b1;
         end else begin
            frame.full = 1'b1;
         end
      end
      frame.opcode = OP_REPLY;
      frame.mac = mac;
      frame.ip = sip;
      frame.slot = slot[SLOT_W-1:0];
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      arp_frame_type frame;
      arp_frame_type want;
      if (reset) begin
         frames_due.delete();
         entries = 0;
         own_mac_copy = '0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_OWN_MAC)
            own_mac_copy = pwdata[MAC_W-1:0];
         if (start && !busy && predict_arp_answer(req_type, req_rx_opcode, req_sender_mac,
                                                  req_sender_ip, req_request_ip, frame))
            frames_due.insert(frames_due.size(), frame);
         if (rsp_valid) begin
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected frame, expected none, got op %h mac %h ip %h",
                        $time, rsp_frame_opcode, rsp_dest_mac, rsp_dest_ip);
               errors++;
            end else begin
               want = frames_due.pop_front();
               check_field("frame_opcode", 64'(want.opcode), 64'(rsp_frame_opcode));
               check_field("dest_mac", 64'(want.mac), 64'(rsp_dest_mac));
               check_field("dest_ip", 64'(want.ip), 64'(rsp_dest_ip));
               check_field("slot_used", 64'(want.slot), 64'(rsp_slot_used));
               check_field("slot_new", 64'(want.is_new), 64'(rsp_slot_new));
               check_field("cache_full", 64'(want.full), 64'(rsp_cache_full));
            end
         end
         pending <= frames_due.size();
      end
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import arpc_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int IP_POOL = 24;
   localparam int PHASE_ITEMS = 150;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_type = REQ_RECEIVED;
   logic [RXOP_W-1:0]  req_rx_opcode = '0;
   logic [MAC_W-1:0]   req_sender_mac = '0;
   logic [IP_W-1:0]    req_sender_ip = '0;
   logic [IP_W-1:0]    req_request_ip = '0;
   logic               rsp_valid;
   logic [OP_W-1:0]    rsp_frame_opcode;
   logic [MAC_W-1:0]   rsp_dest_mac;
   logic [IP_W-1:0]    rsp_dest_ip;
   logic [SLOT_W-1:0]  rsp_slot_used;
   logic               rsp_slot_new;
   logic               rsp_cache_full;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   int                 errors;
   int                 pending;
   int                 cycle_count = 0;
   int                 gap_pct = 0;
   logic [MAC_W-1:0]   own_mac_now = '0;
   logic [IP_W-1:0]    ip_pool[IP_POOL];

   always #6 clock = ~clock;

   arp_responder_with_cache dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_rx_opcode(req_rx_opcode), .req_sender_mac(req_sender_mac),
      .req_sender_ip(req_sender_ip), .req_request_ip(req_request_ip),
      .rsp_valid(rsp_valid), .rsp_frame_opcode(rsp_frame_opcode),
      .rsp_dest_mac(rsp_dest_mac), .rsp_dest_ip(rsp_dest_ip),
      .rsp_slot_used(rsp_slot_used), .rsp_slot_new(rsp_slot_new),
      .rsp_cache_full(rsp_cache_full),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   arp_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_rx_opcode(req_rx_opcode), .req_sender_mac(req_sender_mac),
      .req_sender_ip(req_sender_ip), .req_request_ip(req_request_ip),
      .rsp_valid(rsp_valid), .rsp_frame_opcode(rsp_frame_opcode),
      .rsp_dest_mac(rsp_dest_mac), .rsp_dest_ip(rsp_dest_ip),
      .rsp_slot_used(rsp_slot_used), .rsp_slot_new(rsp_slot_new),
      .rsp_cache_full(rsp_cache_full),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL arp_responder_with_cache");
         $finish;
      end
   end

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_mac(input logic [MAC_W-1:0] mac);
      settle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_OWN_MAC;
      pwdata <= {16'($urandom), mac};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      own_mac_now = mac;
   endtask

   task automatic issue(input logic kind, input logic [RXOP_W-1:0] op,
                        input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] sip,
                        input logic [IP_W-1:0] rip);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_rx_opcode <= op;
      req_sender_mac <= mac;
      req_sender_ip <= sip;
      req_request_ip <= rip;
      do @(posedge clock); while (busy);
   endtask

   task automatic random_request(output bit answered);
      int               choice;
      logic [RXOP_W-1:0] op;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  sip;
      choice = $urandom_range(99);
      op = 16'($urandom);
      mac = {16'($urandom), 32'($urandom)};
      sip = ($urandom_range(9) == 0) ? 32'($urandom) : ip_pool[$urandom_range(IP_POOL - 1)];
      if (choice < 25) begin
         issue(REQ_SEND, op, mac, sip, 32'($urandom));
         answered = 1'b1;
      end else if (choice < 80) begin
         if (mac == own_mac_now)
            mac = ~mac;
         issue(REQ_RECEIVED, RX_OP_REQUEST, mac, sip, 32'($urandom));
         answered = 1'b1;
      end else if (choice < 88) begin
         if ($urandom_range(3) != 0)
            op = RX_OP_REQUEST;
         issue(REQ_RECEIVED, op, own_mac_now, sip, 32'($urandom));
         answered = 1'b0;
      end else begin
         if ($urandom_range(1) == 0)
            op = 16'h0002;
         issue(REQ_RECEIVED, op, mac, sip, 32'($urandom));
         answered = (op == RX_OP_REQUEST && mac != own_mac_now);
      end
   endtask

   initial begin
      int  done;
      bit  answered;
      logic [MAC_W-1:0] mac_set;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int i = 2; i < IP_POOL; i++)
         ip_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_own_mac(48'h02005E102030);
      issue(REQ_SEND, '0, '0, '0, '0);
      issue(REQ_SEND, '1, '1, '1, '1);
      issue(REQ_RECEIVED, RX_OP_REQUEST, '0, '0, '1);
      issue(REQ_RECEIVED, RX_OP_REQUEST, '1, '1, '0);
      issue(REQ_RECEIVED, RX_OP_REQUEST, 48'h00AA55AA55AA, '0, $urandom);
      issue(REQ_RECEIVED, 16'h0002, 48'h001122334455, $urandom, $urandom);
      issue(REQ_RECEIVED, 16'h0000, 48'h001122334455, $urandom, $urandom);
      issue(REQ_RECEIVED, 16'hFFFF, 48'h001122334455, $urandom, $urandom);
      issue(REQ_RECEIVED, RX_OP_REQUEST, own_mac_now, $urandom, $urandom);
      issue(REQ_RECEIVED, 16'h0002, own_mac_now, $urandom, $urandom);
      issue(REQ_RECEIVED, RX_OP_REQUEST, own_mac_now ^ 48'h1, '1, $urandom);
      issue(REQ_SEND, RX_OP_REQUEST, own_mac_now, $urandom, $urandom);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               mac_set = {16'($urandom), 32'($urandom)};
               gap_pct = 0;
            end
            1: begin
               mac_set = '1;
               gap_pct = 62;
            end
            2: begin
               mac_set = '0;
               gap_pct = 17;
            end
            default: begin
               mac_set = {16'($urandom), 32'($urandom)};
               gap_pct = 0;
            end
         endcase
         write_own_mac(mac_set);
         done = 0;
         while (done < PHASE_ITEMS) begin
            random_request(answered);
            done += answered;
            if ($urandom_range(99) < 2)
               settle();
         end
      end

      settle();
      repeat (30) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("PASS arp_responder_with_cache");
      else
         $display("FAIL arp_responder_with_cache");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arpc_ctrl.sv
hdl/arpc_dp.sv
hdl/arp_responder_with_cache.sv
tb/arp_checker.sv
tb/tb_top.sv
